>>> hdl/sha256_byte_stream_hasher_top_assert.svh
// Assertion macros for the SHA-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SHB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define SHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Types, constants and round functions for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package shb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } shb_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } shb_out_t;

  // Datapath commands
  typedef struct packed {
    logic       write_byte;   // store data byte at fill position, count it
    logic       write_pad;    // store pad byte at fill position (0x80 or zero)
    logic       pad_first;    // pad byte is 0x80
    logic       write_len;    // store length byte at fill position
    logic       block_start;  // load working vars and round counter
    logic       round;        // run one round
    logic       block_end;    // fold working vars into chain
    logic       msg_clear;    // return to initial state
  } shb_cmd_t;

  typedef struct packed {
    logic       buf_full;     // fill position at zero (wrapped after a write, or empty)
    logic [5:0] fill;
    logic       last_round;
  } shb_stat_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenPos   = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hdl/shb_datapath.sv
// ----------------------------------------------------------------------------
// shb_datapath
// Block buffer, byte counter, message schedule and one-round-per-cycle
// compression core with the chaining value.
// ----------------------------------------------------------------------------
module shb_datapath import shb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  shb_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output shb_stat_t   stat,
  output logic [31:0] chain [8]
);

  // block held as 16 big-endian words, byte lanes written one at a time
  logic [31:0] block_mem [16];
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [31:0] sched [16];
  logic [31:0] wv [8];
  logic [5:0]  rnd;
  logic [31:0] w_cur, w_new, s0, s1, sig0, sig1, ch, maj, t1, t2;
  logic [31:0] blk_word;

  assign bit_len = {byte_count, 3'b000};
  assign len_sel = fill[2:0];
  assign wr_en   = cmd.write_byte | cmd.write_pad | cmd.write_len;

  always_comb begin
    wr_byte = data_byte;
    if (cmd.write_pad) wr_byte = cmd.pad_first ? PadByte : 8'h00;
    if (cmd.write_len) wr_byte = bit_len[{~len_sel, 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (wr_en) block_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      fill       <= '0;
      byte_count <= '0;
    end else begin
      if (wr_en) fill <= fill + 6'd1;
      if (cmd.write_byte) byte_count <= byte_count + 61'd1;
    end
  end

  assign stat.fill       = fill;
  assign stat.buf_full   = (fill == 6'd0);
  assign stat.last_round = (rnd == 6'd63);

  // Schedule: rounds below 16 read the block, later ones extend the window.
  assign blk_word = block_mem[rnd[3:0]];
  assign s0 = rotr(sched[rnd[3:0] + 4'd1], 7) ^ rotr(sched[rnd[3:0] + 4'd1], 18)
            ^ (sched[rnd[3:0] + 4'd1] >> 3);
  assign s1 = rotr(sched[rnd[3:0] + 4'd14], 17) ^ rotr(sched[rnd[3:0] + 4'd14], 19)
            ^ (sched[rnd[3:0] + 4'd14] >> 10);
  assign w_new = sched[rnd[3:0]] + s0 + sched[rnd[3:0] + 4'd9] + s1;
  assign w_cur = (rnd < 6'd16) ? blk_word : w_new;

  assign sig1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
  assign ch   = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign t1   = wv[7] + sig1 + ch + RoundK[rnd] + w_cur;
  assign sig0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
  assign maj  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t2   = sig0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.round) sched[rnd[3:0]] <= w_cur;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      rnd <= '0;
      for (int j = 0; j < 8; j++) begin
        wv[j]    <= '0;
        chain[j] <= InitH[j];
      end
    end else if (cmd.block_start) begin
      rnd <= '0;
      for (int j = 0; j < 8; j++) wv[j] <= chain[j];
    end else if (cmd.round) begin
      rnd   <= rnd + 6'd1;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end else if (cmd.block_end) begin
      for (int j = 0; j < 8; j++) chain[j] <= chain[j] + wv[j];
    end
  end

endmodule

>>> hdl/shb_ctrl.sv
// ----------------------------------------------------------------------------
// shb_ctrl
// Sequencer: input handshake, padding steps, compression rounds, digest out.
// ----------------------------------------------------------------------------
module shb_ctrl import shb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  shb_in_t     in_word,
  output logic        in_stall,
  input  shb_stat_t   stat,
  output shb_cmd_t    cmd,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_idx
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic       finishing, finishing_next;   // message end pending
  logic       pad_done, pad_done_next;     // 0x80 already placed
  logic       len_phase, len_phase_next;   // final block under way
  logic       pad_extra, pad_extra_next;   // zero-fill to the end of this block first
  logic [1:0] idx, idx_next;
  logic       take;
  logic       cmd_was_byte;                // last accepted word carried a byte

  assign in_stall  = (state != S_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_idx   = idx;

  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    pad_done_next  = pad_done;
    len_phase_next = len_phase;
    pad_extra_next = pad_extra;
    idx_next       = idx;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          cmd.write_byte = in_word.has_byte;
          finishing_next = in_word.end_of_message;
          pad_done_next  = 1'b0;
          len_phase_next = 1'b0;
          pad_extra_next = 1'b0;
          if (in_word.has_byte || in_word.end_of_message) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // full block after a data byte compresses first
        if (stat.buf_full && !pad_done && !len_phase && cmd_was_byte) state_next = S_START;
        else if (finishing) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_PAD: begin
        if (!pad_done) begin
          cmd.write_pad = 1'b1;
          cmd.pad_first = 1'b1;
          pad_done_next = 1'b1;
          // 0x80 landing in the length field forces an extra block
          if (stat.fill >= LenPos) pad_extra_next = 1'b1;
        end else if (pad_extra && stat.fill == 6'd0) begin
          state_next = S_START;
        end else if (pad_extra || stat.fill < LenPos) begin
          cmd.write_pad = 1'b1;
        end else begin
          cmd.write_len = 1'b1;
          len_phase_next = 1'b1;
          if (stat.fill == 6'd63) state_next = S_START;
        end
      end
      S_START: begin
        cmd.block_start = 1'b1;
        pad_extra_next  = 1'b0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.block_end = 1'b1;
        if (len_phase) begin
          idx_next   = 2'd0;
          state_next = S_OUT;
        end else if (finishing) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            cmd.msg_clear  = 1'b1;
            finishing_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_was_byte <= 1'b0;
    end else begin
      if (state == S_IDLE) cmd_was_byte <= take && in_word.has_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finishing <= 1'b0;
      pad_done  <= 1'b0;
      len_phase <= 1'b0;
      pad_extra <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      pad_done  <= pad_done_next;
      len_phase <= len_phase_next;
      pad_extra <= pad_extra_next;
      idx       <= idx_next;
    end
  end

endmodule

>>> hdl/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream; four 64-bit digest words per message.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | shb_in_t  (byte, has_byte, end)
//  out     | output    | out_valid / out_stall| shb_out_t (digest word, index, last)
//
// A plain byte is accepted and then checked; the 64th byte of a block also starts
// a compression in the one-round-per-cycle core. A final item adds padding
// writes (over up to two blocks) and one or two compressions, then
// four out words.
// Reset (rst, synchronous) restores the initial hash. in_stall is high while
// any work is under way; out_stall holds the current digest word.
`include "sha256_byte_stream_hasher_top_assert.svh"
module sha256_byte_stream_hasher_top import shb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  shb_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output shb_out_t out_word
);

  shb_cmd_t    cmd;
  shb_stat_t   stat;
  logic [31:0] chain [8];
  logic [1:0]  idx;

  shb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_word(in_word), .in_stall(in_stall),
    .stat(stat), .cmd(cmd), .out_stall(out_stall), .out_valid(out_valid), .out_idx(idx)
  );

  shb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(in_word.data_byte),
    .stat(stat), .chain(chain)
  );

  assign out_word.digest_word = {chain[{idx, 1'b0}], chain[{idx, 1'b1}]};
  assign out_word.word_index  = idx;
  assign out_word.last_word   = (idx == 2'd3);

  `SHB_ASSERT_IMP(a_no_accept_busy, out_valid, in_stall, "input taken while sending digest")
  `SHB_ASSERT_NEXT(a_hold_word, out_valid && out_stall, out_valid && $stable(idx),
                   "digest word changed under stall")
  `SHB_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.round, cmd.block_start, cmd.block_end}),
                  "conflicting compression commands")

endmodule
